// ----- hdl/bwsg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bwsg_pkg
// Widths, register indexes, shape codes, scale constants and the sine
// table entry function of the band-limited wave sample generator.
// ----------------------------------------------------------------------------
package bwsg_pkg;

  localparam int unsigned MAX_HARMONICS_DEF   = 4096;
  localparam int unsigned SINE_TABLE_SIZE_DEF = 1024;

  localparam int unsigned SAMPLE_INDEX_W = 16;
  localparam int unsigned WAVE_SAMPLE_W  = 24;
  localparam int unsigned SHAPE_W        = 2;
  localparam int unsigned PHASE_STEP_W   = 31;
  localparam int unsigned PHASE_W        = 32;
  localparam int unsigned SINE_W         = 32;
  localparam int unsigned SCALE_W        = 31;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd1;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_SQUARE = 2'd0,
    SHAPE_SAW    = 2'd1,
    SHAPE_TRI    = 2'd2
  } shape_e;

  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST = 31'd3936710;

  localparam logic [SCALE_W-1:0] SCALE_SQUARE = 31'd1367130551;
  localparam logic [SCALE_W-1:0] SCALE_SAW    = 31'd683565276;
  localparam logic [SCALE_W-1:0] SCALE_TRI    = 31'd870342340;

  localparam logic [WAVE_SAMPLE_W-1:0] WAVE_POS_SAT = 24'h7F_FFFF;
  localparam logic [WAVE_SAMPLE_W-1:0] WAVE_NEG_SAT = 24'h80_0000;

  localparam logic [63:0]        HALF_PI_Q32 = 64'd6746518852;
  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;

  // quarter-wave taylor series up to x^15, q30, products truncated
  function automatic logic signed [SINE_W-1:0] sine_q30(input logic [PHASE_W-1:0] p);
    logic [1:0]        quad;
    logic [63:0]       r;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] acc;
    quad = p[31:30];
    r    = {34'd0, p[29:0]};
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HALF_PI_Q32) >> 32;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    acc  = acc - $signed(term);
    if (acc > ONE_Q30) begin
      acc = ONE_Q30;
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    return quad[1] ? SINE_W'(-acc) : SINE_W'(acc);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bwsg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bwsg_if
// Valid/ready stream interfaces for the sample index and the wave sample.
// ----------------------------------------------------------------------------
interface bwsg_in_if import bwsg_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [SAMPLE_INDEX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface bwsg_out_if import bwsg_pkg::*;;
  logic                            valid;
  logic                            ready;
  logic signed [WAVE_SAMPLE_W-1:0] wave_sample;

  modport source (output valid, output wave_sample, input ready);
  modport sink   (input valid, input wave_sample, output ready);
endinterface
`default_nettype wire

// ----- hdl/bwsg_sine_rom.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bwsg_sine_rom
// Full-cycle q30 sine table built at elaboration, registered read.
// ----------------------------------------------------------------------------
module bwsg_sine_rom import bwsg_pkg::*; #(
  parameter int unsigned SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
) (
  input  logic                                 clk_i,
  input  logic [$clog2(SINE_TABLE_SIZE)-1:0]   addr_i,
  output logic signed [SINE_W-1:0]             data_o
);

  typedef logic signed [SINE_W-1:0] tab_t [SINE_TABLE_SIZE];

  function automatic tab_t build_tab();
    tab_t             t;
    logic [PHASE_W-1:0] p;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
      p    = PHASE_W'((64'(i) << 32) / SINE_TABLE_SIZE);
      t[i] = sine_q30(p);
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic signed [SINE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SINE_TAB[addr_i];
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ----- hdl/bwsg_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bwsg_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bwsg_divider import bwsg_pkg::*; #(
  parameter int unsigned DVD_W = SINE_W - 1,
  parameter int unsigned DVS_W = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ----- hdl/bandlimited_wave_sample_generator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bandlimited_wave_sample_generator
// Additive Fourier synthesis of band-limited square, sawtooth and triangle
// samples from a sample index, one harmonic at a time.
// ----------------------------------------------------------------------------
// Each accepted sample index walks the harmonics below Nyquist (at most
// MAX_HARMONICS of them) through one shared serial divider that yields one
// quotient bit per cycle, so every harmonic passes through the phase check,
// the table address, the table read, the divider steps and the divider's
// done cycle, and the accumulate. An undefined shape code skips the
// harmonics and goes straight to the scaling. The input is not ready while
// a word is in work; a finished sample sits in the output register, so the
// next index is taken while it waits.
module bandlimited_wave_sample_generator import bwsg_pkg::*; #(
  parameter int unsigned MAX_HARMONICS   = MAX_HARMONICS_DEF,
  parameter int unsigned SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bwsg_in_if.sink               in_i,
  bwsg_out_if.source            out_o
);

  localparam int unsigned N_W    = $clog2(2 * MAX_HARMONICS);
  localparam int unsigned T_W    = $clog2(MAX_HARMONICS + 1);
  localparam int unsigned DVS_W  = 2 * N_W;
  localparam int unsigned DVD_W  = SINE_W - 1;
  localparam int unsigned SUM_W  = DVD_W + T_W + 1;
  localparam int unsigned A_W    = $clog2(SINE_TABLE_SIZE);
  localparam int unsigned STEP_W = PHASE_STEP_W + 2;
  localparam int unsigned BASE_W = SAMPLE_INDEX_W + PHASE_STEP_W;
  localparam int unsigned IDXP_W = PHASE_W + A_W;
  localparam int unsigned MAG_W  = 33;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned RND_W  = PROD_W - 38;

  localparam logic signed [SUM_W-1:0] SUM_LIM = {{(SUM_W - MAG_W){1'b0}}, 1'b1, 32'd0};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_CHECK,
    ST_ADDR,
    ST_LOAD,
    ST_DIV,
    ST_ACCUM,
    ST_SCALE,
    ST_ROUND
  } state_e;

  state_e                          state_q;
  logic                            out_valid_q;
  logic signed [WAVE_SAMPLE_W-1:0] out_data_q;

  logic [SHAPE_W-1:0]        wave_shape_q;
  logic [PHASE_STEP_W-1:0]   phase_step_q;

  logic [SAMPLE_INDEX_W-1:0] index_q;
  logic [PHASE_W-1:0]        ph_q;
  logic [PHASE_W-1:0]        ph_step_q;
  logic [N_W-1:0]            n_q;
  logic [T_W-1:0]            terms_q;
  logic [STEP_W-1:0]         nstep_q;
  logic [STEP_W-1:0]         nadd_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [A_W-1:0]            addr_q;
  logic [DVS_W-1:0]          divisor_q;
  logic                      s_neg_q;
  logic [PROD_W-1:0]         prod_q;
  logic                      neg_q;

  logic                      in_fire;
  logic                      out_load;
  logic                      odd_only;
  logic                      alt_sign;
  logic                      is_tri;
  logic                      shape_undef;
  logic                      last_term;
  logic [BASE_W-1:0]         base_prod;
  logic [IDXP_W-1:0]         idx_prod;
  logic [DVS_W-1:0]          n_sq;
  logic signed [SINE_W-1:0]  rom_data;
  logic [SINE_W-1:0]         rom_abs;
  logic                      div_start;
  logic                      div_done;
  logic [DVD_W-1:0]          quotient;
  logic                      subtract;
  logic signed [SUM_W-1:0]   term_ext;
  logic signed [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]          sum_abs;
  logic [MAG_W-1:0]          mag;
  logic [SCALE_W-1:0]        scale_c;
  logic [PROD_W-1:0]         prod_d;
  logic [PROD_W-1:0]         rnd_sum;
  logic [RND_W-1:0]          rnd;
  logic [RND_W-1:0]          rnd_neg;
  logic [WAVE_SAMPLE_W-1:0]  out_word;

  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_ROUND) && (!out_valid_q || out_o.ready);
  assign odd_only    = (wave_shape_q != SHAPE_SAW);
  assign alt_sign    = (wave_shape_q != SHAPE_SQUARE);
  assign is_tri      = (wave_shape_q == SHAPE_TRI);
  assign shape_undef = (wave_shape_q > SHAPE_TRI);
  assign last_term   = (terms_q == T_W'(MAX_HARMONICS)) ||
                       (nstep_q[STEP_W-1 -: 2] != 2'b00);

  assign base_prod = index_q * phase_step_q;
  assign idx_prod  = ph_q * IDXP_W'(SINE_TABLE_SIZE);
  assign n_sq      = n_q * n_q;

  assign rom_abs   = rom_data[SINE_W-1] ? SINE_W'(-rom_data) : SINE_W'(rom_data);
  assign div_start = (state_q == ST_LOAD);

  always_comb begin
    subtract = s_neg_q ^ (alt_sign && terms_q[0]);
    term_ext = $signed({{(SUM_W - DVD_W){1'b0}}, quotient});
    sum_next = subtract ? (sum_q - term_ext) : (sum_q + term_ext);
  end

  always_comb begin
    sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    mag     = ($signed(sum_abs) > SUM_LIM) ? SUM_LIM[MAG_W-1:0] : sum_abs[MAG_W-1:0];
    unique case (wave_shape_q)
      SHAPE_SQUARE: scale_c = SCALE_SQUARE;
      SHAPE_SAW:    scale_c = SCALE_SAW;
      SHAPE_TRI:    scale_c = SCALE_TRI;
      default:      scale_c = '0;
    endcase
    prod_d = PROD_W'(mag) * PROD_W'(scale_c);
  end

  always_comb begin
    rnd_sum = prod_q + (PROD_W'(1) << 37);
    rnd     = rnd_sum[PROD_W-1:38];
    rnd_neg = ~rnd + 1'b1;
    if (!neg_q) begin
      out_word = (rnd > RND_W'(WAVE_POS_SAT)) ? WAVE_POS_SAT : rnd[WAVE_SAMPLE_W-1:0];
    end else begin
      out_word = (rnd > RND_W'(WAVE_NEG_SAT)) ? WAVE_NEG_SAT : rnd_neg[WAVE_SAMPLE_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_shape_q <= SHAPE_SQUARE;
      phase_step_q <= PHASE_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAVE_SHAPE: wave_shape_q <= cfg_data_i[SHAPE_W-1:0];
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i[PHASE_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_data_q  <= $signed(out_word);
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= shape_undef ? ST_SCALE : ST_BASE;
          end
        end
        ST_BASE:  state_q <= ST_CHECK;
        ST_CHECK: state_q <= last_term ? ST_SCALE : ST_ADDR;
        ST_ADDR:  state_q <= ST_LOAD;
        ST_LOAD:  state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: state_q <= ST_CHECK;
        ST_SCALE: state_q <= ST_ROUND;
        ST_ROUND: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // harmonic datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          index_q <= in_i.sample_index;
          n_q     <= N_W'(1);
          terms_q <= '0;
          sum_q   <= '0;
          nstep_q <= STEP_W'(phase_step_q);
          nadd_q  <= odd_only ? {1'b0, phase_step_q, 1'b0} : {2'b00, phase_step_q};
        end
      end
      ST_BASE: begin
        ph_q      <= base_prod[PHASE_W-1:0];
        ph_step_q <= odd_only ? {base_prod[PHASE_W-2:0], 1'b0} : base_prod[PHASE_W-1:0];
      end
      ST_CHECK: begin
        addr_q    <= idx_prod[PHASE_W +: A_W];
        divisor_q <= is_tri ? n_sq : DVS_W'(n_q);
      end
      ST_LOAD: s_neg_q <= rom_data[SINE_W-1];
      ST_ACCUM: begin
        sum_q   <= sum_next;
        n_q     <= n_q + (odd_only ? N_W'(2) : N_W'(1));
        ph_q    <= ph_q + ph_step_q;
        nstep_q <= nstep_q + nadd_q;
        terms_q <= terms_q + 1'b1;
      end
      ST_SCALE: begin
        prod_q <= prod_d;
        neg_q  <= sum_q[SUM_W-1];
      end
      default: ;
    endcase
  end

  bwsg_sine_rom #(
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (addr_q),
    .data_o (rom_data)
  );

  bwsg_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rom_abs[DVD_W-1:0]),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.wave_sample = out_data_q;

endmodule
`default_nettype wire

// ----- hdl/bwsg_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bwsg_checker
// Port-level assertions for the band-limited wave sample generator.
// ----------------------------------------------------------------------------
module bwsg_checker import bwsg_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [WAVE_SAMPLE_W-1:0] out_sample_i
);

  // a stalled output word stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sample_i))
    else $error("output word changed while stalled");

  // one word in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again while busy");

  // no result can follow its word in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("output word appeared too early");

endmodule

bind bandlimited_wave_sample_generator bwsg_checker u_bwsg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.wave_sample)
);
`default_nettype wire
